>>> hw/rtl/sprite_evaluation_top_assert.svh
// Assertion macros shared by the checker files of the sprite evaluation block.
`ifndef SPRITE_EVALUATION_TOP_ASSERT_SVH
`define SPRITE_EVALUATION_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define SPREV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent starting in the cycle after its antecedent.
`define SPREV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

>>> hw/rtl/sprev_pkg.sv
// ----------------------------------------------------------------------------
// Sprite evaluation package
// Transaction types, request structs and constants shared by the block.
// ----------------------------------------------------------------------------
package sprev_pkg;

  // Transaction kinds
  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_READ     = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;
  localparam logic [1:0] KIND_SEC_READ = 2'd3;

  // Table geometry
  localparam int         TABLE_ENTRIES = 64;
  localparam int         SLOTS         = 8;
  localparam logic [1:0] ATTR_BYTE     = 2'd2;
  localparam logic [2:0] INDEX_BYTE    = 3'd4;
  localparam logic [7:0] ATTR_MASK     = 8'hE3;
  localparam logic [7:0] FILL_BYTE     = 8'hFF;

  // Dot windows
  localparam logic [8:0] CLEAR_DOT_FIRST = 9'd1;
  localparam logic [8:0] CLEAR_DOT_LAST  = 9'd64;
  localparam logic [8:0] EVAL_DOT_FIRST  = 9'd65;
  localparam logic [8:0] SPRITE0_DOT     = 9'd66;
  localparam logic [8:0] EVAL_DOT_LAST   = 9'd256;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] oam_addr;
    logic [7:0] oam_data;
    logic [7:0] scanline;
    logic [8:0] dot;
    logic [7:0] eval_start_addr;
    logic       status_overflow;
    logic [2:0] slot;
    logic [2:0] slot_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] oam_latch;
    logic [4:0] secondary_addr;
    logic [3:0] sprites_found;
    logic       overflow_pending;
    logic       sprite0_next;
    logic       eval_done;
  } out_t;

  // Primary table access request
  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] addr;
    logic [7:0] wdata;
  } pri_req_t;

  // Secondary table access request
  typedef struct packed {
    logic       clr_en;
    logic [2:0] clr_slot;
    logic       wr_en;
    logic [2:0] wr_slot;
    logic [1:0] wr_byte;
    logic [7:0] wr_data;
    logic       idx_we;
    logic [7:0] idx_data;
    logic       rd_en;
    logic [2:0] rd_slot;
    logic [2:0] rd_byte;
  } sec_req_t;

endpackage

>>> hw/rtl/sprev_primary.sv
// ----------------------------------------------------------------------------
// Primary sprite table
// 256-byte table with one access port; read data is registered and
// attribute bytes are masked on the way out.
// ----------------------------------------------------------------------------
module sprev_primary (
  input  logic                clk,
  input  sprev_pkg::pri_req_t req,
  output logic [7:0]          rdata
);
  import sprev_pkg::*;

  logic [7:0] mem [256];
  logic [7:0] q_r;
  logic       attr_r;

  // Write or read one byte
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      q_r    <= mem[req.addr];
      attr_r <= (req.addr[1:0] == ATTR_BYTE);
    end
  end

  // Mask unimplemented attribute bits
  assign rdata = attr_r ? (q_r & ATTR_MASK) : q_r;

endmodule

>>> hw/rtl/sprev_secondary.sv
// ----------------------------------------------------------------------------
// Secondary sprite table
// Eight slots of Y, tile, attribute, X in a 32-byte memory plus a source
// index register per slot; valid bits make cleared entries read as 0xFF.
// ----------------------------------------------------------------------------
module sprev_secondary (
  input  logic                clk,
  input  logic                rst_n,
  input  sprev_pkg::sec_req_t req,
  output logic [7:0]          rdata
);
  import sprev_pkg::*;

  localparam logic [1:0] SEL_MEM  = 2'd0;
  localparam logic [1:0] SEL_IDX  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;

  logic [7:0]  mem [32];
  logic [31:0] vld_r;
  logic [7:0]  idx_r [SLOTS];
  logic [SLOTS-1:0] idx_vld_r;
  logic [7:0]  q_r;
  logic [7:0]  alt_r;
  logic        hit_r;
  logic [1:0]  sel_r;
  logic [4:0]  wr_addr;
  logic [4:0]  rd_addr;

  assign wr_addr = {req.wr_slot, req.wr_byte};
  assign rd_addr = {req.rd_slot, req.rd_byte[1:0]};

  // Track which entries hold written data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      idx_vld_r <= '0;
    end else begin
      if (req.clr_en) begin
        for (int k = 0; k < 4; k++) begin
          vld_r[{req.clr_slot, 2'(k)}] <= 1'b0;
        end
        idx_vld_r[req.clr_slot] <= 1'b0;
      end
      if (req.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (req.idx_we) begin
        idx_vld_r[req.wr_slot] <= 1'b1;
      end
    end
  end

  // Store bytes and capture read data
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= req.wr_data;
    end
    if (req.idx_we) begin
      idx_r[req.wr_slot] <= req.idx_data;
    end
    if (req.rd_en) begin
      q_r   <= mem[rd_addr];
      hit_r <= vld_r[rd_addr];
      alt_r <= idx_vld_r[req.rd_slot] ? idx_r[req.rd_slot] : FILL_BYTE;
      if (req.rd_byte < INDEX_BYTE) begin
        sel_r <= SEL_MEM;
      end else if (req.rd_byte == INDEX_BYTE) begin
        sel_r <= SEL_IDX;
      end else begin
        sel_r <= SEL_ZERO;
      end
    end
  end

  // Select the byte to return
  always_comb begin
    unique case (sel_r)
      SEL_MEM: rdata = hit_r ? q_r : FILL_BYTE;
      SEL_IDX: rdata = alt_r;
      default: rdata = 8'd0;
    endcase
  end

endmodule

>>> hw/rtl/sprev_eval.sv
// ----------------------------------------------------------------------------
// Sprite evaluation control
// Input register, per-dot evaluation state machine, table requests and the
// result strobe.
// ----------------------------------------------------------------------------
module sprev_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sprev_pkg::in_t      in_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic [7:0]          pri_rdata,
  input  logic [7:0]          sec_rdata,
  output sprev_pkg::pri_req_t pri_req,
  output sprev_pkg::sec_req_t sec_req,
  output logic                out_valid,
  output sprev_pkg::out_t     out_data
);
  import sprev_pkg::*;

  localparam logic [1:0] MODE_SEARCH   = 2'd0;
  localparam logic [1:0] MODE_COPY     = 2'd1;
  localparam logic [1:0] MODE_OVERFLOW = 2'd2;
  localparam logic [1:0] MODE_DONE     = 2'd3;

  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_PRI  = 2'd1;
  localparam logic [1:0] SRC_SEC  = 2'd2;

  in_t        item_r;
  logic       vld_r;
  logic       tall_r;
  logic [6:0] ec_r, ec_nxt;
  logic [1:0] bo_r, bo_nxt;
  logic [1:0] cp_r, cp_nxt;
  logic [3:0] fc_r, fc_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [7:0] latch_r, latch_nxt;
  logic       lfm_r, lfm_nxt;
  logic [4:0] ptr_r, ptr_nxt;
  logic       ovf_r, ovf_nxt;
  logic       s0_r, s0_nxt;
  logic       out_valid_r;
  logic [1:0] src_r, src_nxt;
  logic [7:0] latch_eff;

  function automatic logic f_in_range(input logic [7:0] line, input logic [7:0] y,
                                      input logic tall);
    logic [8:0] lim;
    begin
      lim = {1'b0, y} + (tall ? 9'd16 : 9'd8);
      return (line >= y) && ({1'b0, line} < lim);
    end
  endfunction

  // Bus latch is either held or still in the primary read register
  assign latch_eff = lfm_r ? pri_rdata : latch_r;

  // Evaluate one transaction
  always_comb begin
    logic [5:0] idx;
    logic [2:0] slot;
    logic       inr;
    idx       = 6'(item_r.dot - CLEAR_DOT_FIRST);
    slot      = (fc_r >= 4'(SLOTS)) ? 3'(SLOTS - 1) : fc_r[2:0];
    inr       = f_in_range(item_r.scanline, latch_eff, tall_r);
    ec_nxt    = ec_r;
    bo_nxt    = bo_r;
    cp_nxt    = cp_r;
    fc_nxt    = fc_r;
    mode_nxt  = mode_r;
    latch_nxt = latch_r;
    lfm_nxt   = lfm_r;
    ptr_nxt   = ptr_r;
    ovf_nxt   = ovf_r;
    s0_nxt    = s0_r;
    src_nxt   = SRC_ZERO;
    pri_req   = '0;
    sec_req   = '0;
    if (vld_r) begin
      latch_nxt = latch_eff;
      lfm_nxt   = 1'b0;
      unique case (item_r.kind)
        KIND_WRITE: begin
          pri_req.we    = 1'b1;
          pri_req.addr  = item_r.oam_addr;
          pri_req.wdata = item_r.oam_data;
        end
        KIND_READ: begin
          pri_req.re   = 1'b1;
          pri_req.addr = item_r.oam_addr;
          src_nxt      = SRC_PRI;
        end
        KIND_SEC_READ: begin
          sec_req.rd_en   = 1'b1;
          sec_req.rd_slot = item_r.slot;
          sec_req.rd_byte = item_r.slot_byte;
          src_nxt         = SRC_SEC;
        end
        default: begin
          if (item_r.dot >= CLEAR_DOT_FIRST && item_r.dot <= CLEAR_DOT_LAST) begin
            // Clear phase: force the latch and sweep the slots
            latch_nxt = FILL_BYTE;
            ptr_nxt   = 5'(idx[5:1]);
            if (idx[2:0] == 3'd0) begin
              sec_req.clr_en   = 1'b1;
              sec_req.clr_slot = idx[5:3];
            end
          end else if (item_r.dot >= EVAL_DOT_FIRST && item_r.dot <= EVAL_DOT_LAST) begin
            if (item_r.dot == EVAL_DOT_FIRST) begin
              ec_nxt   = {1'b0, item_r.eval_start_addr[7:2]};
              bo_nxt   = item_r.eval_start_addr[1:0];
              cp_nxt   = 2'd0;
              fc_nxt   = 4'd0;
              ptr_nxt  = 5'd0;
              mode_nxt = MODE_SEARCH;
              s0_nxt   = 1'b0;
            end
            if (mode_nxt != MODE_DONE) begin
              if (item_r.dot[0]) begin
                // Odd dot: latch a primary byte
                pri_req.re   = 1'b1;
                pri_req.addr = {ec_nxt[5:0], bo_nxt} +
                               ((mode_nxt == MODE_COPY) ? {6'd0, cp_nxt} : 8'd0);
                lfm_nxt      = 1'b1;
              end else begin
                // Even dot: act on the latched byte
                unique case (mode_r)
                  MODE_SEARCH: begin
                    if (inr) begin
                      sec_req.wr_en   = 1'b1;
                      sec_req.wr_slot = slot;
                      sec_req.wr_byte = 2'd0;
                      sec_req.wr_data = latch_eff;
                      ptr_nxt         = ptr_r + 5'd1;
                      if (item_r.dot == SPRITE0_DOT) begin
                        s0_nxt = 1'b1;
                      end
                      cp_nxt   = 2'd1;
                      mode_nxt = MODE_COPY;
                    end else begin
                      ec_nxt = ec_r + 7'd1;
                      if (ec_nxt >= 7'(TABLE_ENTRIES)) begin
                        mode_nxt = MODE_DONE;
                      end
                    end
                  end
                  MODE_COPY: begin
                    sec_req.wr_en   = 1'b1;
                    sec_req.wr_slot = slot;
                    sec_req.wr_byte = cp_r;
                    sec_req.wr_data = latch_eff;
                    ptr_nxt         = ptr_r + 5'd1;
                    if (cp_r != 2'd3) begin
                      cp_nxt = cp_r + 2'd1;
                    end else begin
                      sec_req.idx_we   = 1'b1;
                      sec_req.idx_data = {1'b0, ec_r};
                      fc_nxt           = fc_r + 4'd1;
                      ec_nxt           = ec_r + 7'd1;
                      cp_nxt           = 2'd0;
                      if (ec_nxt >= 7'(TABLE_ENTRIES)) begin
                        mode_nxt = MODE_DONE;
                      end else if (fc_nxt < 4'(SLOTS)) begin
                        mode_nxt = MODE_SEARCH;
                      end else begin
                        bo_nxt   = 2'd0;
                        mode_nxt = MODE_OVERFLOW;
                      end
                    end
                  end
                  MODE_OVERFLOW: begin
                    // Scan with the diagonal address step
                    if (inr) begin
                      if (!item_r.status_overflow) begin
                        ovf_nxt = 1'b1;
                      end
                      bo_nxt = bo_r + 2'd1;
                      if (bo_r == 2'd3) begin
                        ec_nxt = ec_r + 7'd1;
                      end
                    end else begin
                      ec_nxt = ec_r + 7'd1;
                      bo_nxt = bo_r + 2'd1;
                    end
                    if (ec_nxt >= 7'(TABLE_ENTRIES)) begin
                      mode_nxt = MODE_DONE;
                    end
                  end
                  default: begin
                    mode_nxt = MODE_DONE;
                  end
                endcase
              end
            end
          end
        end
      endcase
    end
  end

  // Capture transactions and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      tall_r <= 1'b0;
    end else begin
      vld_r <= start;
      if (cfg_we) begin
        tall_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item_r <= in_data;
    end
  end

  // Advance evaluation state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r        <= 7'd0;
      bo_r        <= 2'd0;
      cp_r        <= 2'd0;
      fc_r        <= 4'd0;
      mode_r      <= MODE_DONE;
      latch_r     <= FILL_BYTE;
      lfm_r       <= 1'b0;
      ptr_r       <= 5'd0;
      ovf_r       <= 1'b0;
      s0_r        <= 1'b0;
      out_valid_r <= 1'b0;
      src_r       <= SRC_ZERO;
    end else begin
      ec_r        <= ec_nxt;
      bo_r        <= bo_nxt;
      cp_r        <= cp_nxt;
      fc_r        <= fc_nxt;
      mode_r      <= mode_nxt;
      latch_r     <= latch_nxt;
      lfm_r       <= lfm_nxt;
      ptr_r       <= ptr_nxt;
      ovf_r       <= ovf_nxt;
      s0_r        <= s0_nxt;
      out_valid_r <= vld_r;
      if (vld_r) begin
        src_r <= src_nxt;
      end
    end
  end

  // Drive the result
  always_comb begin
    unique case (src_r)
      SRC_PRI: out_data.read_data = pri_rdata;
      SRC_SEC: out_data.read_data = sec_rdata;
      default: out_data.read_data = 8'd0;
    endcase
    out_data.oam_latch        = latch_eff;
    out_data.secondary_addr   = ptr_r;
    out_data.sprites_found    = fc_r;
    out_data.overflow_pending = ovf_r;
    out_data.sprite0_next     = s0_r;
    out_data.eval_done        = (mode_r == MODE_DONE);
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/sprite_evaluation_top.sv
// ----------------------------------------------------------------------------
// Sprite evaluation top level
// Per-dot sprite evaluation with primary and secondary sprite tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_data and raise start; a transaction is taken at
//   each rising edge with start high and busy low. busy stays low, so one
//   transaction can be taken every cycle.
//   Result channel: each transaction gives one result on out_data, marked by
//   out_valid for one cycle. The receiver cannot stall; results must be
//   taken as they come.
//   Configuration: cfg_we with cfg_wdata writes tall_sprites; write it only
//   while no transaction is in flight.
//   Throughput is one transaction per cycle; each result passes the input
//   register and the registered read ports of the two tables.
//   Reset (rst_n low, synchronous): evaluation is done, bus latch reads 0xFF,
//   all counters and flags clear, and the secondary table reads 0xFF through
//   valid bits, with no clearing pass. The primary table is undefined until
//   written.
// ----------------------------------------------------------------------------
module sprite_evaluation_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sprev_pkg::in_t  in_data,
  output logic            out_valid,
  output sprev_pkg::out_t out_data,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);
  import sprev_pkg::*;

  pri_req_t   pri_req;
  sec_req_t   sec_req;
  logic [7:0] pri_rdata;
  logic [7:0] sec_rdata;

  // Always ready for the next transaction
  assign busy = 1'b0;

  sprev_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pri_rdata (pri_rdata),
    .sec_rdata (sec_rdata),
    .pri_req   (pri_req),
    .sec_req   (sec_req),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  sprev_primary u_primary (
    .clk   (clk),
    .req   (pri_req),
    .rdata (pri_rdata)
  );

  sprev_secondary u_secondary (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sec_req),
    .rdata (sec_rdata)
  );

endmodule

>>> hw/rtl/sprev_checker.sv
// ----------------------------------------------------------------------------
// Sprite evaluation checker
// Port-level assertions on result timing and flag behavior, bound to the top.
// ----------------------------------------------------------------------------
`include "sprite_evaluation_top_assert.svh"

module sprev_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input sprev_pkg::out_t out_data
);
  import sprev_pkg::*;

  // Every taken transaction yields a result, after the input and result registers
  `SPREV_ASSERT_NEXT(a_result_follows, clk, rst_n, start && !busy, ##1 out_valid, "result missing after transaction")

  // No result without an earlier taken transaction
  `SPREV_ASSERT_NOW(a_no_spurious, clk, rst_n, out_valid, $past(start && !busy, 2), "result without transaction")

  // Pending overflow only clears on reset
  `SPREV_ASSERT_NOW(a_overflow_sticky, clk, rst_n, $past(rst_n) && $past(out_data.overflow_pending), out_data.overflow_pending, "overflow pending dropped")

  // Found count never passes the slot count
  `SPREV_ASSERT_NOW(a_found_bound, clk, rst_n, out_valid, out_data.sprites_found <= 4'(SLOTS), "sprites found out of range")

endmodule

bind sprite_evaluation_top sprev_checker u_sprev_checker (.*);

>>> verif/tb_sprite_evaluation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite evaluation testbench
// Drives table writes, table reads, dot ticks and secondary table reads into
// the block. A local predictor of the evaluation sequencer works out each
// result, and a checker compares every result, field by field, with the
// oldest prediction. After a few directed checks, random scanlines with sprites
// planted near the line run the search, copy and overflow scans, with idle
// gaps, noise and a few broken dot sequences.
// ----------------------------------------------------------------------------
module tb_sprite_evaluation_top;
  import sprev_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEM_COUNT   = 1350;
  localparam int IDLE_PERCENT = 19;
  localparam int DRAIN_CYCLES = 6;
  localparam int SLOT_BYTES   = 5;

  typedef enum logic [1:0] {EV_SEARCH, EV_COPY, EV_OVERFLOW, EV_DONE} ev_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_we;
  logic cfg_wdata;

  // Predicted state of the evaluation sequencer
  logic [7:0] pri_mem [256];
  logic [7:0] sec_mem [SLOTS*SLOT_BYTES];
  logic [6:0] entry_cnt;
  logic [2:0] byte_ofs;
  logic [1:0] copy_pos;
  logic [3:0] found_cnt;
  ev_mode_t   mode;
  logic [7:0] bus_latch;
  logic [4:0] sec_ptr;
  logic       ovf_pending;
  logic       spr0_flag;
  logic       tall_mode;

  out_t expected_results[$];
  out_t oldest_result;
  int   errors = 0;
  int   cycle_count = 0;
  int   counted_items = 0;
  bit   gaps_on = 1'b1;

  sprite_evaluation_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  task automatic model_reset();
    foreach (sec_mem[i]) sec_mem[i] = FILL_BYTE;
    entry_cnt   = '0;
    byte_ofs    = '0;
    copy_pos    = '0;
    found_cnt   = '0;
    mode        = EV_DONE;
    bus_latch   = FILL_BYTE;
    sec_ptr     = '0;
    ovf_pending = 1'b0;
    spr0_flag   = 1'b0;
    tall_mode   = 1'b0;
  endtask

  // Mask the unused attribute bits on the way out of the primary table
  function automatic logic [7:0] pri_fetch(logic [7:0] addr);
    logic [7:0] v;
    v = pri_mem[addr];
    if (addr[1:0] == ATTR_BYTE) begin
      v = v & ATTR_MASK;
    end
    return v;
  endfunction

  function automatic bit y_hit(logic [7:0] line, logic [7:0] y);
    int height;
    height = tall_mode ? 16 : 8;
    return (int'(line) >= int'(y)) && (int'(line) < int'(y) + height);
  endfunction

  // Latch one primary byte; copy reads wrap within the 8-bit address
  task automatic eval_latch();
    logic [7:0] addr;
    addr = {entry_cnt[5:0], byte_ofs[1:0]};
    if (mode == EV_COPY) begin
      addr = addr + copy_pos;
    end
    if (mode != EV_DONE) begin
      bus_latch = pri_fetch(addr);
    end
  endtask

  // Act on the latched byte according to the evaluation mode
  task automatic eval_act(logic [8:0] dot, logic [7:0] line, logic status);
    int base;
    base = ((found_cnt < SLOTS) ? int'(found_cnt) : SLOTS - 1) * SLOT_BYTES;
    case (mode)
      EV_SEARCH: begin
        if (y_hit(line, bus_latch)) begin
          sec_mem[base] = bus_latch;
          sec_ptr = sec_ptr + 5'd1;
          if (dot == SPRITE0_DOT) begin
            spr0_flag = 1'b1;
          end
          copy_pos = 2'd1;
          mode = EV_COPY;
        end else begin
          entry_cnt = entry_cnt + 7'd1;
          if (entry_cnt >= TABLE_ENTRIES) begin
            mode = EV_DONE;
          end
        end
      end
      EV_COPY: begin
        sec_mem[base + copy_pos] = bus_latch;
        sec_ptr = sec_ptr + 5'd1;
        if (copy_pos < 2'd3) begin
          copy_pos = copy_pos + 2'd1;
        end else begin
          sec_mem[base + INDEX_BYTE] = {1'b0, entry_cnt};
          found_cnt = found_cnt + 4'd1;
          entry_cnt = entry_cnt + 7'd1;
          copy_pos = 2'd0;
          if (entry_cnt >= TABLE_ENTRIES) begin
            mode = EV_DONE;
          end else if (found_cnt < SLOTS) begin
            mode = EV_SEARCH;
          end else begin
            byte_ofs = 3'd0;
            mode = EV_OVERFLOW;
          end
        end
      end
      EV_OVERFLOW: begin
        // Diagonal scan: a miss advances both the entry and the byte offset
        if (y_hit(line, bus_latch)) begin
          if (!status) begin
            ovf_pending = 1'b1;
          end
          byte_ofs = byte_ofs + 3'd1;
          if (byte_ofs >= 3'd4) begin
            byte_ofs = 3'd0;
            entry_cnt = entry_cnt + 7'd1;
          end
        end else begin
          entry_cnt = entry_cnt + 7'd1;
          byte_ofs = (byte_ofs + 3'd1) & 3'd3;
        end
        if (entry_cnt >= TABLE_ENTRIES) begin
          mode = EV_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic dot_tick(logic [8:0] dot, logic [7:0] line, logic [7:0] start_addr,
                          logic status);
    int idx;
    if (dot >= CLEAR_DOT_FIRST && dot <= CLEAR_DOT_LAST) begin
      // Clear pass: one secondary slot every eight dots
      idx = int'(dot) - 1;
      bus_latch = FILL_BYTE;
      sec_ptr = 5'((idx >> 1) & 31);
      if (idx % 8 == 0) begin
        for (int k = 0; k < SLOT_BYTES; k++) begin
          sec_mem[(idx / 8) * SLOT_BYTES + k] = FILL_BYTE;
        end
      end
    end else if (dot >= EVAL_DOT_FIRST && dot <= EVAL_DOT_LAST) begin
      if (dot == EVAL_DOT_FIRST) begin
        entry_cnt = {1'b0, start_addr[7:2]};
        byte_ofs  = {1'b0, start_addr[1:0]};
        copy_pos  = 2'd0;
        found_cnt = 4'd0;
        sec_ptr   = 5'd0;
        mode      = EV_SEARCH;
        spr0_flag = 1'b0;
      end
      if (mode != EV_DONE) begin
        if (dot[0]) begin
          eval_latch();
        end else begin
          eval_act(dot, line, status);
        end
      end
    end
  endtask

  task automatic eval_model_step(input in_t it, output out_t res);
    res = '0;
    case (it.kind)
      KIND_WRITE: begin
        pri_mem[it.oam_addr] = it.oam_data;
      end
      KIND_READ: begin
        res.read_data = pri_fetch(it.oam_addr);
      end
      KIND_TICK: begin
        dot_tick(it.dot, it.scanline, it.eval_start_addr, it.status_overflow);
      end
      KIND_SEC_READ: begin
        if (it.slot_byte <= INDEX_BYTE) begin
          res.read_data = sec_mem[it.slot * SLOT_BYTES + it.slot_byte];
        end
      end
      default: ;
    endcase
    res.oam_latch        = bus_latch;
    res.secondary_addr   = sec_ptr;
    res.sprites_found    = found_cnt;
    res.overflow_pending = ovf_pending;
    res.sprite0_next     = spr0_flag;
    res.eval_done        = (mode == EV_DONE);
  endtask

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  function automatic in_t random_item();
    in_t it;
    it.kind            = 2'($urandom_range(3));
    it.oam_addr        = 8'($urandom_range(255));
    it.oam_data        = 8'($urandom_range(255));
    it.scanline        = 8'($urandom_range(255));
    it.dot             = 9'($urandom_range(340));
    it.eval_start_addr = 8'($urandom_range(255));
    it.status_overflow = 1'($urandom_range(1));
    it.slot            = 3'($urandom_range(7));
    it.slot_byte       = 3'($urandom_range(7));
    return it;
  endfunction

  // Send one transaction, idling at random first, and record its prediction
  task automatic send_item(input in_t it);
    out_t res;
    while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    counted_items++;
    eval_model_step(it, res);
    expected_results.push_back(res);
  endtask

  task automatic send_tick(int dot, logic [7:0] line, logic [7:0] start_addr, logic status);
    in_t it;
    it = random_item();
    it.kind            = KIND_TICK;
    it.dot             = 9'(dot);
    it.scanline        = line;
    it.eval_start_addr = start_addr;
    it.status_overflow = status;
    send_item(it);
  endtask

  task automatic send_write(logic [7:0] addr, logic [7:0] data);
    in_t it;
    it = random_item();
    it.kind     = KIND_WRITE;
    it.oam_addr = addr;
    it.oam_data = data;
    send_item(it);
  endtask

  task automatic send_read(logic [7:0] addr);
    in_t it;
    it = random_item();
    it.kind     = KIND_READ;
    it.oam_addr = addr;
    send_item(it);
  endtask

  task automatic send_sec_read(logic [2:0] slot, logic [2:0] slot_byte);
    in_t it;
    it = random_item();
    it.kind      = KIND_SEC_READ;
    it.slot      = slot;
    it.slot_byte = slot_byte;
    send_item(it);
  endtask

  // Hold the sender until every predicted result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tall(input logic value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tall_mode = value;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none outstanding: expected none actual %h",
                 $time, out_data);
        errors++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("read_data", oldest_result.read_data, out_data.read_data);
        check_field("oam_latch", oldest_result.oam_latch, out_data.oam_latch);
        check_field("secondary_addr", oldest_result.secondary_addr,
                    out_data.secondary_addr);
        check_field("sprites_found", oldest_result.sprites_found, out_data.sprites_found);
        check_field("overflow_pending", oldest_result.overflow_pending,
                    out_data.overflow_pending);
        check_field("sprite0_next", oldest_result.sprite0_next, out_data.sprite0_next);
        check_field("eval_done", oldest_result.eval_done, out_data.eval_done);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Ticks that change nothing and secondary reads straight after reset
  task automatic test_idle_after_reset();
    send_tick(100, 8'h40, 8'h00, 1'b0);
    send_tick(0, 8'h00, 8'hFF, 1'b1);
    send_tick(340, 8'hFF, 8'h00, 1'b0);
    send_tick(257, 8'h10, 8'h00, 1'b0);
    send_sec_read(3'd0, 3'd0);
    send_sec_read(3'd7, INDEX_BYTE);
    send_sec_read(3'd3, 3'd7);
  endtask

  // Write every primary byte so that no read ever touches an unwritten one
  task automatic test_table_fill();
    for (int a = 0; a < 256; a++) begin
      send_write(8'(a), 8'($urandom_range(255)));
    end
  endtask

  // Data extremes and the attribute mask
  task automatic test_table_access();
    send_write(8'h02, 8'hFF);
    send_read(8'h02);
    send_write(8'hFF, 8'h00);
    send_read(8'hFF);
    send_write(8'h00, 8'hFF);
    send_read(8'h00);
    send_read(8'h03);
  endtask

  // Misaligned start on the last entry: the copy wraps to address zero,
  // and the entry is only in range with tall sprites
  task automatic test_wrap_line();
    write_tall(1'b1);
    send_write(8'hFD, 8'hF0);
    for (int d = 65; d <= 74; d++) begin
      send_tick(d, 8'hFC, 8'hFD, 1'b0);
    end
    send_sec_read(3'd0, 3'd0);
    send_sec_read(3'd0, 3'd3);
    send_sec_read(3'd0, INDEX_BYTE);
    write_tall(1'b0);
  endtask

  // One scanline: plant sprites near the line, optionally clear, then evaluate
  task automatic run_line(int line_no);
    logic [7:0] line;
    logic [7:0] start_addr;
    logic       status;
    int         height;
    int         offs;
    int         first_dot;
    int         pause_dot;
    int         extra;
    int         pick;
    in_t        it;
    line       = 8'($urandom_range(255));
    height     = tall_mode ? 16 : 8;
    start_addr = ($urandom_range(99) < 70) ? 8'h00 : 8'($urandom_range(255));
    status     = ($urandom_range(99) < 25);
    first_dot  = $urandom_range(1) ? 1 : 65;
    pause_dot  = (line_no == 0) ? 100 :
                 ($urandom_range(99) < 30) ? $urandom_range(first_dot, 256) : 0;
    extra      = $urandom_range(6);

    // Plant Y bytes in and just around the range of this line
    repeat ($urandom_range(2, 14)) begin
      offs = $urandom_range(height);
      send_write({6'($urandom_range(63)), 2'b00},
                 (int'(line) >= offs) ? 8'(int'(line) - offs) : 8'(line + 8'd1));
    end

    for (int d = first_dot; d <= 256; d++) begin
      // Stop at the item budget, or a few dots after evaluation has finished
      if (counted_items >= ITEM_COUNT) break;
      if (d > 67 && mode == EV_DONE) begin
        if (extra == 0) break;
        extra--;
      end
      if (d == pause_dot) begin
        drain_results();
      end
      if ($urandom_range(99) < 4) begin
        it = random_item();
        pick = $urandom_range(2);
        it.kind = (pick == 0) ? KIND_WRITE : (pick == 1) ? KIND_READ : KIND_SEC_READ;
        send_item(it);
      end
      if ($urandom_range(999) < 3) begin
        it = random_item();
        it.kind = KIND_TICK;
        send_item(it);
      end
      send_tick(d, line, (d == 65) ? start_addr : 8'($urandom_range(255)), status);
    end

    // Dots past the evaluation window, then inspect the secondary table
    if ($urandom_range(1)) begin
      repeat (3) send_tick($urandom_range(257, 340), line, 8'($urandom_range(255)), status);
    end
    repeat (6) send_sec_read(3'($urandom_range(7)), 3'($urandom_range(7)));
  endtask

  task automatic test_random_lines();
    int line_no;
    line_no = 0;
    while (counted_items < ITEM_COUNT) begin
      if (line_no % 2 == 0) begin
        write_tall(~tall_mode);
      end
      gaps_on = (line_no % 4 != 1);
      run_line(line_no);
      line_no++;
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Run control
  // --------------------------------------------------------------------------
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_after_reset();
    test_table_fill();
    test_table_access();
    test_wrap_line();
    test_random_lines();

    drain_results();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sprite_evaluation_top.f
+incdir+hw/rtl
hw/rtl/sprev_pkg.sv
hw/rtl/sprev_primary.sv
hw/rtl/sprev_secondary.sv
hw/rtl/sprev_eval.sv
hw/rtl/sprite_evaluation_top.sv
hw/rtl/sprev_checker.sv
verif/tb_sprite_evaluation_top.sv
